// ----- rtl/core/secp_pkg.sv -----
// Shared constants, opcode codes and a helper function for the secp256k1 field ALU.
package secp_pkg;

    localparam logic [255:0] P    = 256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2F;
    localparam logic [255:0] P_M2 = 256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2D;
    localparam logic [31:0]  FOLD_LO = 32'd977;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_NEG = 3'd1,
        OP_MUL = 3'd2,
        OP_SQR = 3'd3,
        OP_INV = 3'd4
    } opcode_t;

    function automatic logic [255:0] canon(input logic [255:0] v);
        logic [255:0] r;
        r = (v >= P) ? (v - P) : v;
        return r;
    endfunction

endpackage

// ----- rtl/core/secp_if.sv -----
// Valid/ready channel interfaces for operand items and result items.
interface secp_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [63:0] a_word0;
    logic [63:0] a_word1;
    logic [63:0] a_word2;
    logic [63:0] a_word3;
    logic [63:0] b_word0;
    logic [63:0] b_word1;
    logic [63:0] b_word2;
    logic [63:0] b_word3;

    modport source (
        output valid, opcode, a_word0, a_word1, a_word2, a_word3,
               b_word0, b_word1, b_word2, b_word3,
        input  ready
    );
    modport sink (
        input  valid, opcode, a_word0, a_word1, a_word2, a_word3,
               b_word0, b_word1, b_word2, b_word3,
        output ready
    );
endinterface

interface secp_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] res_word0;
    logic [63:0] res_word1;
    logic [63:0] res_word2;
    logic [63:0] res_word3;

    modport source (
        output valid, res_word0, res_word1, res_word2, res_word3,
        input  ready
    );
    modport sink (
        input  valid, res_word0, res_word1, res_word2, res_word3,
        output ready
    );
endinterface

// ----- rtl/core/secp_mulred.sv -----
// Iterative modular multiplier: one shared 32x32 multiplier, then fold by 2^256 = 2^32 + 977.
module secp_mulred (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [255:0] x,
    input  logic [255:0] y,
    output logic         done,
    output logic [255:0] res
);
    import secp_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE, M_MAC, M_MACL, M_FINIT, M_FOLD, M_FOLDL, M_RED, M_CAN
    } mstate_t;

    mstate_t      state_reg;
    logic [5:0]   k_reg;
    logic         pend_reg;
    logic         done_reg;

    logic [255:0] x_reg;
    logic [255:0] y_reg;
    logic [511:0] t_reg;
    logic [288:0] u_reg;
    logic [63:0]  prod_reg;
    logic [3:0]   off_reg;
    logic [255:0] res_reg;

    logic [2:0]   i_dig;
    logic [2:0]   j_dig;
    logic [31:0]  mul_a;
    logic [31:0]  mul_b;
    logic [63:0]  prod_w;
    logic [511:0] t_add;
    logic [288:0] u_add;
    logic [288:0] u_init;
    logic [32:0]  h;
    logic [42:0]  h977;
    logic [288:0] u_red;

    assign i_dig  = k_reg[5:3];
    assign j_dig  = k_reg[2:0];
    assign mul_a  = (state_reg == M_MAC) ? x_reg[{i_dig, 5'b0} +: 32]
                                         : t_reg[{1'b1, j_dig, 5'b0} +: 32];
    assign mul_b  = (state_reg == M_MAC) ? y_reg[{j_dig, 5'b0} +: 32] : FOLD_LO;
    assign prod_w = {32'd0, mul_a} * {32'd0, mul_b};
    assign t_add  = t_reg + ({448'd0, prod_reg} << {off_reg, 5'b0});
    assign u_add  = u_reg + ({225'd0, prod_reg} << {off_reg[2:0], 5'b0});
    assign u_init = {33'd0, t_reg[255:0]} + {1'b0, t_reg[511:256], 32'd0};
    assign h      = u_reg[288:256];
    assign h977   = {10'd0, h} * 43'd977;
    assign u_red  = {33'd0, u_reg[255:0]} + {224'd0, h, 32'd0} + {246'd0, h977};

    assign done = done_reg;
    assign res  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            k_reg     <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        k_reg     <= '0;
                        pend_reg  <= 1'b0;
                        state_reg <= M_MAC;
                    end
                end
                M_MAC:
                begin
                    pend_reg <= 1'b1;
                    k_reg    <= k_reg + 6'd1;
                    if (k_reg == 6'd63)
                        state_reg <= M_MACL;
                end
                M_MACL:  state_reg <= M_FINIT;
                M_FINIT:
                begin
                    pend_reg  <= 1'b0;
                    k_reg     <= '0;
                    state_reg <= M_FOLD;
                end
                M_FOLD:
                begin
                    pend_reg <= 1'b1;
                    k_reg    <= k_reg + 6'd1;
                    if (k_reg[2:0] == 3'd7)
                        state_reg <= M_FOLDL;
                end
                M_FOLDL: state_reg <= M_RED;
                M_RED:
                begin
                    if (h == 33'd0)
                        state_reg <= M_CAN;
                end
                M_CAN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    x_reg <= x;
                    y_reg <= y;
                    t_reg <= '0;
                end
            end
            M_MAC:
            begin
                prod_reg <= prod_w;
                off_reg  <= {1'b0, i_dig} + {1'b0, j_dig};
                if (pend_reg)
                    t_reg <= t_add;
            end
            M_MACL:  t_reg <= t_add;
            M_FINIT: u_reg <= u_init;
            M_FOLD:
            begin
                prod_reg <= prod_w;
                off_reg  <= {1'b0, j_dig};
                if (pend_reg)
                    u_reg <= u_add;
            end
            M_FOLDL: u_reg <= u_add;
            M_RED:
            begin
                if (h != 33'd0)
                    u_reg <= u_red;
            end
            M_CAN:   res_reg <= canon(u_reg[255:0]);
            default: ;
        endcase
    end

endmodule

// ----- rtl/core/secp256k1_field_alu.sv -----
// Top level of the secp256k1 prime field ALU: sequencer around the shared multiplier.
//
// in_ch carries an opcode (add, negate, multiply, square, invert) and two
// 256-bit operands as four 64-bit words; out_ch returns one canonical result
// in [0,p) per item. Operands are reduced mod p on transfer.
// One item is worked on at a time: in_ch.ready is high only while the block
// is idle, and stays low until the result has been taken on out_ch.
// Work from input transfer to result valid:
//   add: a registered sum, then a conditional subtract of p;
//   negate and unused opcodes: result set at dispatch;
//   multiply and square: 64 multiply-accumulate steps on the single 32x32
//   multiplier, 8 fold steps, then reduce steps until bits 288:256 are zero;
//   invert: 505 modular multiplies, set by the square-and-multiply walk over the 256 bits of p-2.
// The result is held in a register on out_ch for as long as out_ch.ready
// stays low; nothing is lost under stall.
// Reset returns the sequencer and the multiplier to idle; any item in flight
// is dropped.
module secp256k1_field_alu (
    input logic       clk,
    input logic       rst_n,
    secp_in_if.sink   in_ch,
    secp_out_if.source out_ch
);
    import secp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_ADD, S_ADDC, S_MUL, S_MULW,
        S_ISQ, S_ISQW, S_IML, S_IMLW, S_OUT
    } state_t;

    state_t       state_reg;
    logic [7:0]   bit_reg;

    logic [2:0]   op_reg;
    logic [255:0] a_reg;
    logic [255:0] b_reg;
    logic [255:0] acc_reg;
    logic [256:0] sum_reg;
    logic [255:0] res_reg;

    logic         in_xfer;
    logic         mul_start;
    logic [255:0] mul_x;
    logic [255:0] mul_y;
    logic         mul_done;
    logic [255:0] mul_res;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_xfer     = in_ch.valid && in_ch.ready;

    assign out_ch.valid     = (state_reg == S_OUT);
    assign out_ch.res_word0 = res_reg[63:0];
    assign out_ch.res_word1 = res_reg[127:64];
    assign out_ch.res_word2 = res_reg[191:128];
    assign out_ch.res_word3 = res_reg[255:192];

    always_comb
    begin
        mul_start = 1'b0;
        mul_x     = a_reg;
        mul_y     = (op_reg == OP_SQR) ? a_reg : b_reg;
        unique case (state_reg)
            S_MUL: mul_start = 1'b1;
            S_ISQ:
            begin
                mul_start = 1'b1;
                mul_x     = acc_reg;
                mul_y     = acc_reg;
            end
            S_IML:
            begin
                mul_start = 1'b1;
                mul_x     = acc_reg;
                mul_y     = a_reg;
            end
            default: ;
        endcase
    end

    secp_mulred u_mulred (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .done  (mul_done),
        .res   (mul_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bit_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                        state_reg <= S_DISP;
                end
                S_DISP:
                begin
                    bit_reg <= 8'd255;
                    unique case (op_reg)
                        OP_ADD:          state_reg <= S_ADD;
                        OP_MUL, OP_SQR:  state_reg <= S_MUL;
                        OP_INV:          state_reg <= S_ISQ;
                        default:         state_reg <= S_OUT;
                    endcase
                end
                S_ADD:  state_reg <= S_ADDC;
                S_ADDC: state_reg <= S_OUT;
                S_MUL:  state_reg <= S_MULW;
                S_MULW:
                begin
                    if (mul_done)
                        state_reg <= S_OUT;
                end
                S_ISQ:  state_reg <= S_ISQW;
                S_ISQW:
                begin
                    if (mul_done)
                    begin
                        if (P_M2[bit_reg])
                            state_reg <= S_IML;
                        else if (bit_reg == 8'd0)
                            state_reg <= S_OUT;
                        else
                        begin
                            bit_reg   <= bit_reg - 8'd1;
                            state_reg <= S_ISQ;
                        end
                    end
                end
                S_IML:  state_reg <= S_IMLW;
                S_IMLW:
                begin
                    if (mul_done)
                    begin
                        if (bit_reg == 8'd0)
                            state_reg <= S_OUT;
                        else
                        begin
                            bit_reg   <= bit_reg - 8'd1;
                            state_reg <= S_ISQ;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    op_reg <= in_ch.opcode;
                    a_reg  <= canon({in_ch.a_word3, in_ch.a_word2,
                                     in_ch.a_word1, in_ch.a_word0});
                    b_reg  <= canon({in_ch.b_word3, in_ch.b_word2,
                                     in_ch.b_word1, in_ch.b_word0});
                end
            end
            S_DISP:
            begin
                acc_reg <= 256'd1;
                unique case (op_reg)
                    OP_NEG:  res_reg <= (a_reg == 256'd0) ? 256'd0 : (P - a_reg);
                    default: res_reg <= '0;
                endcase
            end
            S_ADD:  sum_reg <= {1'b0, a_reg} + {1'b0, b_reg};
            S_ADDC: res_reg <= (sum_reg >= {1'b0, P}) ? sum_reg[255:0] - P : sum_reg[255:0];
            S_MULW:
            begin
                if (mul_done)
                    res_reg <= mul_res;
            end
            S_ISQW, S_IMLW:
            begin
                if (mul_done)
                begin
                    acc_reg <= mul_res;
                    res_reg <= mul_res;
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- rtl/core/secp_alu_chk.sv -----
// Port-level checker for the secp256k1 field ALU, bound to the top level.
module secp_alu_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] res_word0
);

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is pending");

    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready stayed high after an input transfer");

    a_idle_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> (in_ready && !out_valid))
        else $error("block not idle after result transfer");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(res_word0)))
        else $error("stalled result changed");

endmodule

bind secp256k1_field_alu secp_alu_chk u_secp_alu_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .res_word0 (out_ch.res_word0)
);

// ----- verif/tb_secp256k1_field_alu.sv -----
// Self-checking testbench for secp256k1_field_alu: directed and random field operations.
module tb_secp256k1_field_alu;
    timeunit 1ns;
    timeprecision 1ps;
    import secp_pkg::*;

    localparam int          HALF_PERIOD = 6;
    localparam int          RESET_CYCLES = 7;
    localparam int          RANDOM_ITEMS = 2000;
    localparam int          QUIET_ITEMS = 300;
    localparam int          INVERT_BUDGET = 6;
    localparam longint      CYCLE_LIMIT = 3000000;
    localparam int          DRAIN_CYCLES = 20;
    localparam logic [2:0]  OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0]  OP_UNUSED_LAST = 3'd7;
    localparam logic [255:0] ALL_ONES = {256{1'b1}};

    logic clk = 1'b0;
    logic rst_n;
    logic quiet = 1'b0;
    int   errors = 0;
    int   stall_left;
    longint cycles = 0;
    logic [255:0] expected_results[$];

    secp_in_if  in_ch ();
    secp_out_if out_ch ();

    secp256k1_field_alu i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [255:0] reduce_once(input logic [255:0] v);
        return (v >= P) ? v - P : v;
    endfunction

    function automatic logic [255:0] mod_mul(input logic [255:0] x, input logic [255:0] y);
        logic [511:0] prod;
        prod = {256'd0, x} * {256'd0, y};
        prod = prod % {256'd0, P};
        return prod[255:0];
    endfunction

    function automatic logic [255:0] field_result(input logic [2:0] op,
                                                  input logic [255:0] a_raw,
                                                  input logic [255:0] b_raw);
        logic [255:0] a;
        logic [255:0] b;
        logic [256:0] sum;
        logic [255:0] acc;
        logic [255:0] e;
        a = reduce_once(a_raw);
        b = reduce_once(b_raw);
        e = P - 256'd2;
        case (op)
            OP_ADD:
            begin
                sum = {1'b0, a} + {1'b0, b};
                if (sum >= {1'b0, P})
                    sum = sum - {1'b0, P};
                return sum[255:0];
            end
            OP_NEG: return (a == 256'd0) ? 256'd0 : P - a;
            OP_MUL: return mod_mul(a, b);
            OP_SQR: return mod_mul(a, a);
            OP_INV:
            begin
                acc = 256'd1;
                for (int i = 255; i >= 0; i--)
                begin
                    acc = mod_mul(acc, acc);
                    if (e[i])
                        acc = mod_mul(acc, a);
                end
                return acc;
            end
            default: return 256'd0;
        endcase
    endfunction

    // Result side: random stall bursts unless quiet.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left <= 0;
        end
        else if (quiet)
            out_ch.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 13);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        logic [255:0] want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transfer");
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_ch.res_word0 !== want[63:0])
                begin
                    $error("res_word0 expected %h actual %h", want[63:0], out_ch.res_word0);
                    errors++;
                end
                if (out_ch.res_word1 !== want[127:64])
                begin
                    $error("res_word1 expected %h actual %h", want[127:64], out_ch.res_word1);
                    errors++;
                end
                if (out_ch.res_word2 !== want[191:128])
                begin
                    $error("res_word2 expected %h actual %h", want[191:128], out_ch.res_word2);
                    errors++;
                end
                if (out_ch.res_word3 !== want[255:192])
                begin
                    $error("res_word3 expected %h actual %h", want[255:192], out_ch.res_word3);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(input logic [2:0] op, input logic [255:0] a,
                             input logic [255:0] b);
        in_ch.valid   <= 1'b1;
        in_ch.opcode  <= op;
        in_ch.a_word0 <= a[63:0];
        in_ch.a_word1 <= a[127:64];
        in_ch.a_word2 <= a[191:128];
        in_ch.a_word3 <= a[255:192];
        in_ch.b_word0 <= b[63:0];
        in_ch.b_word1 <= b[127:64];
        in_ch.b_word2 <= b[191:128];
        in_ch.b_word3 <= b[255:192];
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_results.push_back(field_result(op, a, b));
    endtask

    task automatic hold_off(input int n);
        in_ch.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [255:0] rand_operand();
        logic [255:0] v;
        case ($urandom_range(0, 9))
            0: v = 256'd0;
            1: v = P - 256'($urandom_range(0, 3));
            2: v = P + 256'($urandom_range(0, 1000));
            3: v = ALL_ONES - 256'($urandom_range(0, 3));
            4: v = 256'($urandom_range(0, 5));
            default:
                v = {$urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom};
        endcase
        return v;
    endfunction

    task automatic test_add();
        send_item(OP_ADD, 256'd0, 256'd0);
        send_item(OP_ADD, P - 256'd1, P - 256'd1);
        send_item(OP_ADD, ALL_ONES, ALL_ONES);
        send_item(OP_ADD, P, 256'd1);
        send_item(OP_ADD, P - 256'd1, 256'd1);
    endtask

    task automatic test_negate();
        send_item(OP_NEG, 256'd0, ALL_ONES);
        send_item(OP_NEG, P, 256'd0);
        send_item(OP_NEG, 256'd1, 256'd0);
        send_item(OP_NEG, ALL_ONES, 256'd0);
    endtask

    task automatic test_multiply();
        send_item(OP_MUL, ALL_ONES, ALL_ONES);
        send_item(OP_MUL, P - 256'd1, P - 256'd1);
        send_item(OP_MUL, 256'd0, ALL_ONES);
        send_item(OP_SQR, P - 256'd1, 256'd0);
        send_item(OP_SQR, ALL_ONES, 256'd7);
    endtask

    task automatic test_invert();
        send_item(OP_INV, 256'd0, 256'd0);
        send_item(OP_INV, 256'd1, ALL_ONES);
        send_item(OP_INV, P - 256'd1, 256'd0);
        send_item(OP_INV, P + 256'd2, 256'd0);
    endtask

    task automatic test_unused_opcodes();
        for (logic [3:0] op = {1'b0, OP_UNUSED_FIRST}; op <= {1'b0, OP_UNUSED_LAST}; op++)
            send_item(op[2:0], rand_operand(), rand_operand());
    endtask

    task automatic test_random();
        logic [2:0] op;
        int inv_left;
        int pick;
        inv_left = INVERT_BUDGET;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
            begin
                wait_drained();
                quiet <= 1'b1;
            end
            if (n == RANDOM_ITEMS / 2)
                wait_drained();
            pick = $urandom_range(0, 99);
            if (inv_left > 0 && $urandom_range(0, 249) == 0)
            begin
                op = OP_INV;
                inv_left--;
            end
            else if (pick < 25)
                op = OP_ADD;
            else if (pick < 45)
                op = OP_NEG;
            else if (pick < 70)
                op = OP_MUL;
            else if (pick < 91)
                op = OP_SQR;
            else
                op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
            if (!quiet && $urandom_range(0, 5) == 0)
                hold_off($urandom_range(1, 14));
            send_item(op, rand_operand(), rand_operand());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.opcode <= OP_ADD;
        in_ch.a_word0 <= '0;
        in_ch.a_word1 <= '0;
        in_ch.a_word2 <= '0;
        in_ch.a_word3 <= '0;
        in_ch.b_word0 <= '0;
        in_ch.b_word1 <= '0;
        in_ch.b_word2 <= '0;
        in_ch.b_word3 <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_add();
        test_negate();
        test_multiply();
        test_invert();
        test_unused_opcodes();
        test_random();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
